/* hw/rtl/spl2s_pkg.sv */
// Shared constants, codes and command/status types for the linked two-stack pool.
// Used by spl2s_ctrl, spl2s_dpath and shared_pool_linked_two_stacks; depends on nothing.
package spl2s_pkg;

   localparam int unsigned POOL_PAIRS = 1024;
   localparam int unsigned ADDR_W     = $clog2(POOL_PAIRS);
   localparam int unsigned LINK_W     = ADDR_W + 1;
   localparam int unsigned VALUE_W    = 64;
   localparam int unsigned MODE_W     = 2;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned DEPTH_W    = 11;
   localparam int unsigned RSP_DATA_W = 88;

   localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(POOL_PAIRS);
   localparam logic [LINK_W-1:0] TOP_CELL  = LINK_W'(POOL_PAIRS - 1);
   localparam logic [LINK_W-1:0] FILL_INIT = LINK_W'(POOL_PAIRS);

   localparam logic [MODE_W-1:0] MODE_PUSH_DATA = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP_DATA  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PUSH_RET  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_POP_RET   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic load;
      logic commit;
   } spl2s_cmd_type;

   typedef struct packed {
      logic out_valid;
   } spl2s_stat_type;

endpackage

/* hw/rtl/spl2s_ctrl.sv */
// Controller state machine for the linked two-stack pool.
// Depends on spl2s_pkg; drives load and commit commands into spl2s_dpath.
module spl2s_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic                      rsp_tready,
   input  spl2s_pkg::spl2s_stat_type stat,
   output spl2s_pkg::spl2s_cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      out_free;

   assign out_free   = !stat.out_valid || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/spl2s_dpath.sv */
// Datapath for the linked two-stack pool: cell memories, stack tops, free list and result register.
// Depends on spl2s_pkg; acts on commands from spl2s_ctrl.
module spl2s_dpath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  spl2s_pkg::spl2s_cmd_type              cmd,
   output spl2s_pkg::spl2s_stat_type             stat,
   input  logic [spl2s_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [spl2s_pkg::VALUE_W-1:0]  req_value,
   input  logic                                  rsp_tready,
   output logic                                  rsp_valid,
   output logic signed [spl2s_pkg::VALUE_W-1:0]  rsp_pop_value,
   output logic [spl2s_pkg::STATUS_W-1:0]        rsp_status,
   output logic [spl2s_pkg::DEPTH_W-1:0]         rsp_data_depth,
   output logic [spl2s_pkg::DEPTH_W-1:0]         rsp_return_depth
);

   localparam int unsigned AW = spl2s_pkg::ADDR_W;
   localparam int unsigned LW = spl2s_pkg::LINK_W;
   localparam int unsigned VW = spl2s_pkg::VALUE_W;

   logic [VW-1:0] val_mem [spl2s_pkg::POOL_PAIRS];
   logic [LW-1:0] link_mem [spl2s_pkg::POOL_PAIRS];

   logic [spl2s_pkg::MODE_W-1:0] mode_ff;
   logic [VW-1:0]                value_ff;
   logic [VW-1:0]                val_rd_ff;
   logic [LW-1:0]                link_rd_ff;
   logic [LW-1:0]                free_head_ff, free_head_in;
   logic [LW-1:0]                data_top_ff, data_top_in;
   logic [LW-1:0]                ret_top_ff, ret_top_in;
   logic [LW-1:0]                data_cnt_ff, data_cnt_in;
   logic [LW-1:0]                ret_cnt_ff, ret_cnt_in;
   logic [LW-1:0]                fill_ff, fill_in;
   logic                         out_valid_ff;
   logic [VW-1:0]                out_value_ff;
   logic [spl2s_pkg::STATUS_W-1:0] out_status_ff;
   logic [spl2s_pkg::DEPTH_W-1:0]  out_ddepth_ff;
   logic [spl2s_pkg::DEPTH_W-1:0]  out_rdepth_ff;

   logic          req_is_pop;
   logic          req_is_ret;
   logic [LW-1:0] rd_link;
   logic          is_pop;
   logic          is_ret;
   logic [LW-1:0] sel_top;
   logic [LW-1:0] sel_cnt;
   logic [LW-1:0] new_top;
   logic [LW-1:0] new_cnt;
   logic          full;
   logic          empty;
   logic          ok;
   logic          fresh;
   logic [LW-1:0] link_wr_data;
   logic [LW-1:0] link_wr_cell;
   logic [VW-1:0] pop_value;
   logic [spl2s_pkg::STATUS_W-1:0] status;

   // The read side works on the item being accepted, before mode_ff is loaded.
   assign req_is_pop = (req_mode == spl2s_pkg::MODE_POP_DATA) ||
                       (req_mode == spl2s_pkg::MODE_POP_RET);
   assign req_is_ret = (req_mode == spl2s_pkg::MODE_PUSH_RET) ||
                       (req_mode == spl2s_pkg::MODE_POP_RET);

   always_comb begin
      if (!req_is_pop) begin
         rd_link = free_head_ff;
      end else if (req_is_ret) begin
         rd_link = ret_top_ff;
      end else begin
         rd_link = data_top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff    <= req_mode;
         value_ff   <= req_value;
         val_rd_ff  <= val_mem[rd_link[AW-1:0]];
         link_rd_ff <= link_mem[rd_link[AW-1:0]];
      end
   end

   assign is_pop  = (mode_ff == spl2s_pkg::MODE_POP_DATA) ||
                    (mode_ff == spl2s_pkg::MODE_POP_RET);
   assign is_ret  = (mode_ff == spl2s_pkg::MODE_PUSH_RET) ||
                    (mode_ff == spl2s_pkg::MODE_POP_RET);
   assign sel_top = is_ret ? ret_top_ff : data_top_ff;
   assign sel_cnt = is_ret ? ret_cnt_ff : data_cnt_ff;
   assign full    = (free_head_ff >= spl2s_pkg::NIL_LINK);
   assign empty   = (sel_top >= spl2s_pkg::NIL_LINK);
   assign ok      = is_pop ? !empty : !full;

   // Cells below the fill mark were never handed out and their link is never written, so the
   // next free cell after one of them is the cell one lower, not one read from the link memory.
   assign fresh   = (free_head_ff < fill_ff);

   always_comb begin
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      new_top      = sel_top;
      new_cnt      = sel_cnt;
      link_wr_cell = free_head_ff;
      link_wr_data = sel_top;
      pop_value    = '0;
      status       = spl2s_pkg::ST_OK;
      if (is_pop) begin
         link_wr_cell = sel_top;
         link_wr_data = free_head_ff;
         if (empty) begin
            status = spl2s_pkg::ST_EMPTY;
         end else begin
            pop_value    = val_rd_ff;
            new_top      = link_rd_ff;
            new_cnt      = sel_cnt - LW'(1);
            free_head_in = sel_top;
         end
      end else begin
         if (full) begin
            status = spl2s_pkg::ST_FULL;
         end else begin
            new_top = free_head_ff;
            new_cnt = sel_cnt + LW'(1);
            if (fresh) begin
               fill_in      = free_head_ff;
               free_head_in = (free_head_ff == '0) ? spl2s_pkg::NIL_LINK
                                                   : free_head_ff - LW'(1);
            end else begin
               free_head_in = link_rd_ff;
            end
         end
      end
      data_top_in = data_top_ff;
      ret_top_in  = ret_top_ff;
      data_cnt_in = data_cnt_ff;
      ret_cnt_in  = ret_cnt_ff;
      if (is_ret) begin
         ret_top_in = new_top;
         ret_cnt_in = new_cnt;
      end else begin
         data_top_in = new_top;
         data_cnt_in = new_cnt;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && ok) begin
         link_mem[link_wr_cell[AW-1:0]] <= link_wr_data;
         if (!is_pop) begin
            val_mem[free_head_ff[AW-1:0]] <= value_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= spl2s_pkg::TOP_CELL;
         fill_ff      <= spl2s_pkg::FILL_INIT;
         data_top_ff  <= spl2s_pkg::NIL_LINK;
         ret_top_ff   <= spl2s_pkg::NIL_LINK;
         data_cnt_ff  <= '0;
         ret_cnt_ff   <= '0;
      end else if (cmd.commit) begin
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         data_top_ff  <= data_top_in;
         ret_top_ff   <= ret_top_in;
         data_cnt_ff  <= data_cnt_in;
         ret_cnt_ff   <= ret_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         out_value_ff  <= pop_value;
         out_status_ff <= status;
         out_ddepth_ff <= spl2s_pkg::DEPTH_W'(data_cnt_in);
         out_rdepth_ff <= spl2s_pkg::DEPTH_W'(ret_cnt_in);
      end
   end

   assign stat.out_valid   = out_valid_ff;
   assign rsp_valid        = out_valid_ff;
   assign rsp_pop_value    = out_value_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_data_depth   = out_ddepth_ff;
   assign rsp_return_depth = out_rdepth_ff;

endmodule

/* hw/rtl/shared_pool_linked_two_stacks.sv */
// Top level of the shared pool holding a data stack and a return stack as linked lists.
// Depends on spl2s_pkg, spl2s_ctrl and spl2s_dpath.
//
//   Channel   Direction  Payload
//   req_*     in         tuser: mode; tdata: push_value
//   rsp_*     out        tuser: status; tdata: pop_value, data_depth, return_depth
//
// Each beat is handled as a registered read of the cell memories, followed by an update
// of the lists and a write-back of the link and value.
// The free list is handed out from the highest cell down right after reset, with no
// clearing pass, so the first beat may arrive in the cycle after reset falls.
// A finished result waits in an output register; while it is not taken the next beat
// can be accepted but its update waits until the result is taken.
module shared_pool_linked_two_stacks (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [spl2s_pkg::VALUE_W-1:0]        req_tdata,   // [63:0] push_value
   input  logic [spl2s_pkg::MODE_W-1:0]         req_tuser,   // [1:0] mode
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [63:0] pop_value, [74:64] data_depth, [85:75] return_depth, [87:86] zero
   output logic [spl2s_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [spl2s_pkg::STATUS_W-1:0]       rsp_tuser    // [1:0] status
);

   spl2s_pkg::spl2s_cmd_type  cmd;
   spl2s_pkg::spl2s_stat_type stat;

   logic signed [spl2s_pkg::VALUE_W-1:0] pop_value;
   logic [spl2s_pkg::DEPTH_W-1:0]        data_depth;
   logic [spl2s_pkg::DEPTH_W-1:0]        return_depth;

   spl2s_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   spl2s_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_mode         (req_tuser),
      .req_value        (req_tdata),
      .rsp_tready       (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_pop_value    (pop_value),
      .rsp_status       (rsp_tuser),
      .rsp_data_depth   (data_depth),
      .rsp_return_depth (return_depth)
   );

   assign rsp_tdata = {2'b00, return_depth, data_depth, pop_value};

   // A beat is never accepted in the cycle right after another one.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("beat accepted while the previous one is still in progress");

   // Every commit leaves a result waiting on the output.
   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_tvalid)
      else $error("commit did not present a result");

   // A full pool means both stacks together hold every cell.
   a_full_depth: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == spl2s_pkg::ST_FULL) |->
         ({1'b0, data_depth} + {1'b0, return_depth} ==
          (spl2s_pkg::DEPTH_W + 1)'(spl2s_pkg::POOL_PAIRS)))
      else $error("pool reported full with cells unaccounted for");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for the two linked stacks sharing one cell pool: directed edge beats,
// then random fill and mixed phases. Random idles and stalls are applied on both channels.
// Depends on spl2s_pkg and the shared_pool_linked_two_stacks RTL.
module tb_top;

   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      logic [spl2s_pkg::MODE_W-1:0]  mode;
      logic [spl2s_pkg::VALUE_W-1:0] value;
   } stack_op_type;

   typedef struct packed {
      logic [spl2s_pkg::VALUE_W-1:0]  pop_value;
      logic [spl2s_pkg::STATUS_W-1:0] status;
      logic [spl2s_pkg::DEPTH_W-1:0]  data_depth;
      logic [spl2s_pkg::DEPTH_W-1:0]  return_depth;
   } stack_rsp_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [spl2s_pkg::VALUE_W-1:0]    req_tdata = '0;
   logic [spl2s_pkg::MODE_W-1:0]     req_tuser = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [spl2s_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [spl2s_pkg::STATUS_W-1:0]   rsp_tuser;

   shared_pool_linked_two_stacks DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // Mirror of the pool: cell contents, free list head, both stack tops and depths.
   logic [spl2s_pkg::VALUE_W-1:0] pool_value [spl2s_pkg::POOL_PAIRS];
   logic [spl2s_pkg::LINK_W-1:0]  pool_link  [spl2s_pkg::POOL_PAIRS];
   logic [spl2s_pkg::LINK_W-1:0]  pool_free_head;
   logic [spl2s_pkg::LINK_W-1:0]  data_top_cell;
   logic [spl2s_pkg::LINK_W-1:0]  ret_top_cell;
   logic [spl2s_pkg::DEPTH_W-1:0] data_depth_q;
   logic [spl2s_pkg::DEPTH_W-1:0] ret_depth_q;

   stack_op_type  pending_ops [$];
   stack_rsp_type expected_results [$];
   stack_op_type  next_op;
   stack_op_type  accepted_op;
   stack_rsp_type got_rsp;
   int            beats_accepted = 0;
   int            total_ops = 0;
   int            error_count = 0;
   int            cycle_count = 0;
   int            req_gap = 0;
   int            rsp_hold = 0;
   int            rsp_next_hold;
   bit            req_calm = 1'b0;
   bit            rsp_calm = 1'b0;

   function automatic stack_rsp_type apply_stack_op(stack_op_type op);
      stack_rsp_type                 rsp;
      logic [spl2s_pkg::LINK_W-1:0]  top;
      logic [spl2s_pkg::LINK_W-1:0]  slot;
      logic [spl2s_pkg::DEPTH_W-1:0] depth;
      bit                            use_ret;
      use_ret = (op.mode == spl2s_pkg::MODE_PUSH_RET) || (op.mode == spl2s_pkg::MODE_POP_RET);
      top     = use_ret ? ret_top_cell : data_top_cell;
      depth   = use_ret ? ret_depth_q : data_depth_q;
      rsp.pop_value = '0;
      rsp.status    = spl2s_pkg::ST_OK;
      if ((op.mode == spl2s_pkg::MODE_PUSH_DATA) || (op.mode == spl2s_pkg::MODE_PUSH_RET)) begin
         slot = pool_free_head;
         if (slot >= spl2s_pkg::LINK_W'(spl2s_pkg::POOL_PAIRS)) begin
            rsp.status = spl2s_pkg::ST_FULL;
         end else begin
            pool_free_head                          = pool_link[slot[spl2s_pkg::ADDR_W-1:0]];
            pool_value[slot[spl2s_pkg::ADDR_W-1:0]] = op.value;
            pool_link[slot[spl2s_pkg::ADDR_W-1:0]]  = top;
            top                                     = slot;
            depth                                   = depth + 1'b1;
         end
      end else begin
         slot = top;
         if (slot >= spl2s_pkg::LINK_W'(spl2s_pkg::POOL_PAIRS)) begin
            rsp.status = spl2s_pkg::ST_EMPTY;
         end else begin
            rsp.pop_value                          = pool_value[slot[spl2s_pkg::ADDR_W-1:0]];
            top                                    = pool_link[slot[spl2s_pkg::ADDR_W-1:0]];
            pool_link[slot[spl2s_pkg::ADDR_W-1:0]] = pool_free_head;
            pool_free_head                         = slot;
            depth                                  = depth - 1'b1;
         end
      end
      if (use_ret) begin
         ret_top_cell = top;
         ret_depth_q  = depth;
      end else begin
         data_top_cell = top;
         data_depth_q  = depth;
      end
      rsp.data_depth   = data_depth_q;
      rsp.return_depth = ret_depth_q;
      return rsp;
   endfunction

   function automatic logic [spl2s_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return {1'b1, {(spl2s_pkg::VALUE_W-1){1'b0}}};
         1: return {1'b0, {(spl2s_pkg::VALUE_W-1){1'b1}}};
         2: return '1;
         3: return '0;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic add_op(logic [spl2s_pkg::MODE_W-1:0] mode,
                         logic [spl2s_pkg::VALUE_W-1:0] value);
      stack_op_type op;
      op.mode  = mode;
      op.value = value;
      pending_ops.push_back(op);
   endtask

   task automatic check_field(string name, logic [spl2s_pkg::VALUE_W-1:0] exp,
                              logic [spl2s_pkg::VALUE_W-1:0] act);
      if (exp !== act) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
         error_count++;
      end
   endtask

   // Request driver: holds a beat until taken, then idles for a drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            accepted_op.mode  = req_tuser;
            accepted_op.value = req_tdata;
            expected_results.push_back(apply_stack_op(accepted_op));
            beats_accepted++;
         end
         if (req_gap != 0) begin
            req_tvalid <= 1'b0;
            req_gap    <= req_gap - 1;
         end else if (pending_ops.size() != 0) begin
            next_op = pending_ops.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_op.mode;
            req_tdata  <= next_op.value;
            if ($urandom_range(0, 29) == 0) req_calm = !req_calm;
            req_gap <= req_calm ? 0 : $urandom_range(0, 4);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response monitor: checks each taken beat and stalls for a drawn number of cycles after it.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= 0;
      end else begin
         rsp_next_hold = rsp_hold;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual status %h data %h",
                        $time, rsp_tuser, rsp_tdata);
               error_count++;
            end else begin
               got_rsp = expected_results.pop_front();
               check_field("pop_value", got_rsp.pop_value, rsp_tdata[63:0]);
               check_field("status", spl2s_pkg::VALUE_W'(got_rsp.status),
                           spl2s_pkg::VALUE_W'(rsp_tuser));
               check_field("data_depth", spl2s_pkg::VALUE_W'(got_rsp.data_depth),
                           spl2s_pkg::VALUE_W'(rsp_tdata[74:64]));
               check_field("return_depth", spl2s_pkg::VALUE_W'(got_rsp.return_depth),
                           spl2s_pkg::VALUE_W'(rsp_tdata[85:75]));
            end
            if ($urandom_range(0, 29) == 0) rsp_calm = !rsp_calm;
            rsp_next_hold = rsp_calm ? 0 : $urandom_range(0, 4);
         end
         if (rsp_next_hold != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= rsp_next_hold - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_hold   <= 0;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int k;
      for (k = 0; k < spl2s_pkg::POOL_PAIRS; k++) begin
         pool_value[k] = '0;
         pool_link[k]  = (k == 0) ? spl2s_pkg::NIL_LINK : spl2s_pkg::LINK_W'(k - 1);
      end
      pool_free_head = spl2s_pkg::TOP_CELL;
      data_top_cell  = spl2s_pkg::NIL_LINK;
      ret_top_cell   = spl2s_pkg::NIL_LINK;
      data_depth_q   = '0;
      ret_depth_q    = '0;

      // Pops on empty stacks, extreme values, interleaving of the two stacks.
      add_op(spl2s_pkg::MODE_POP_DATA, '1);
      add_op(spl2s_pkg::MODE_POP_RET, '0);
      add_op(spl2s_pkg::MODE_PUSH_DATA, {1'b1, {(spl2s_pkg::VALUE_W-1){1'b0}}});
      add_op(spl2s_pkg::MODE_PUSH_DATA, {1'b0, {(spl2s_pkg::VALUE_W-1){1'b1}}});
      add_op(spl2s_pkg::MODE_PUSH_RET, '0);
      add_op(spl2s_pkg::MODE_PUSH_RET, '1);
      add_op(spl2s_pkg::MODE_POP_RET, 64'h0123_4567_89ab_cdef);
      add_op(spl2s_pkg::MODE_POP_DATA, '0);
      add_op(spl2s_pkg::MODE_POP_DATA, '1);
      add_op(spl2s_pkg::MODE_POP_DATA, '0);
      add_op(spl2s_pkg::MODE_POP_RET, '0);
      add_op(spl2s_pkg::MODE_POP_RET, '1);
      add_op(spl2s_pkg::MODE_PUSH_DATA, 64'h5555_5555_5555_5555);
      add_op(spl2s_pkg::MODE_PUSH_RET, 64'haaaa_aaaa_aaaa_aaaa);
      add_op(spl2s_pkg::MODE_PUSH_DATA, 64'haaaa_aaaa_aaaa_aaaa);
      add_op(spl2s_pkg::MODE_POP_DATA, '1);
      add_op(spl2s_pkg::MODE_POP_RET, '1);
      add_op(spl2s_pkg::MODE_POP_DATA, 64'h5555_5555_5555_5555);

      // Push-heavy phase that exhausts the pool and keeps hitting the full case.
      for (k = 0; k < 1100; k++) begin
         if ($urandom_range(0, 99) < 98)
            add_op($urandom_range(0, 1) ? spl2s_pkg::MODE_PUSH_RET : spl2s_pkg::MODE_PUSH_DATA,
                   pick_value());
         else
            add_op($urandom_range(0, 1) ? spl2s_pkg::MODE_POP_RET : spl2s_pkg::MODE_POP_DATA,
                   pick_value());
      end
      for (k = 0; k < 300; k++) begin
         if ($urandom_range(0, 99) < 45)
            add_op($urandom_range(0, 1) ? spl2s_pkg::MODE_PUSH_RET : spl2s_pkg::MODE_PUSH_DATA,
                   pick_value());
         else
            add_op($urandom_range(0, 1) ? spl2s_pkg::MODE_POP_RET : spl2s_pkg::MODE_POP_DATA,
                   pick_value());
      end
      total_ops = pending_ops.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (beats_accepted != total_ops) @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/spl2s_pkg.sv
hw/rtl/spl2s_ctrl.sv
hw/rtl/spl2s_dpath.sv
hw/rtl/shared_pool_linked_two_stacks.sv
tb/tb_top.sv
